[rtl/core/tlrb_pkg.sv]
// ============================================================================
// Tagged log record ring buffer - shared package
// Types, codes and helpers shared by the front, back and top of the logger.
// ============================================================================
package tlrb_pkg;

    // Ring and id space sizes
    localparam int RING_DEPTH = 8192;
    localparam int ID_COUNT   = 1024;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int FILL_W     = 14;
    localparam int MAP_DEPTH  = 128;
    localparam int MAP_AW     = $clog2(MAP_DEPTH);

    // Item commands
    typedef enum logic [2:0] {
        CMD_OPEN  = 3'd0,
        CMD_CLOSE = 3'd1,
        CMD_ENW   = 3'd2,
        CMD_BYTE  = 3'd3,
        CMD_HALF  = 3'd4,
        CMD_WORD  = 3'd5,
        CMD_TIME  = 3'd6,
        CMD_POP   = 3'd7
    } t_cmd;

    // Record size class
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_HALF = 2'd1,
        KIND_WORD = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DELTA_ID  = 2'd0,
        CFG_MARKER_ID = 2'd1,
        CFG_ALWAYS_ID = 2'd2,
        CFG_BYTE_LIM  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0] delta_id;
        logic [4:0] marker_id;
        logic [9:0] always_id;
        logic [5:0] byte_limit;
    } t_cfg;

    // Classified item handed from front to back
    typedef struct packed {
        t_cmd        cmd;
        t_kind       kind;
        logic [9:0]  id;
        logic [31:0] payload;
        logic [31:0] ts;
        logic [6:0]  eidx;
        logic [7:0]  ebits;
        logic        eclr;
    } t_item;

    typedef struct packed {
        logic              acc;
        logic              pv;
        logic [15:0]       pw;
        logic [FILL_W-1:0] fill;
        logic              drop;
    } t_result;

    // Store words high byte first
    function automatic logic [15:0] swap16(input logic [15:0] w);
        return {w[7:0], w[15:8]};
    endfunction

endpackage

[rtl/core/tagged_log_record_ring_buffer_top.sv]
// ============================================================================
// Tagged log record ring buffer - top level
// Logger packing tagged records into a ring of 16-bit words, with pops.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  item in  | push / full            | i_cmd, i_record_id, i_payload, ...
//  result   | pop / empty            | o_accepted, o_pop_valid, o_popped_word,
//           |                        | o_fill_level, o_drop_pending
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Each item has a check and a result step (open, close, pop, refused
// records); an enable write adds a read-modify-write of the map byte and
// a record a write for each of its ring words, drop marker included (up
// to 4), via the single ring write port. One item is worked on at a time,
// a second waits in the front queue. Up to two results wait for the reader.
// Reset is synchronous; the ring contents are not cleared.
// ============================================================================
module tagged_log_record_ring_buffer_top import tlrb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [9:0]  i_record_id,
    input  logic [31:0] i_payload,
    input  logic [31:0] i_timestamp,
    input  logic [6:0]  i_enable_index,
    input  logic [7:0]  i_enable_bits,
    input  logic        i_clear_map_first,
    input  logic        pop,
    output logic        empty,
    output logic        o_accepted,
    output logic        o_pop_valid,
    output logic [15:0] o_popped_word,
    output logic [13:0] o_fill_level,
    output logic        o_drop_pending,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_item   item;
    logic    item_valid;
    logic    item_take;
    t_result result;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delta_id   <= 5'd0;
            r_cfg.marker_id  <= 5'd1;
            r_cfg.always_id  <= 10'd2;
            r_cfg.byte_limit <= 6'd32;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DELTA_ID:  r_cfg.delta_id   <= i_cfg_data[4:0];
                CFG_MARKER_ID: r_cfg.marker_id  <= i_cfg_data[4:0];
                CFG_ALWAYS_ID: r_cfg.always_id  <= i_cfg_data;
                CFG_BYTE_LIM:  r_cfg.byte_limit <= i_cfg_data[5:0];
                default:       r_cfg            <= r_cfg;
            endcase
        end
    end

    tlrb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_cmd             (i_cmd),
        .i_record_id       (i_record_id),
        .i_payload         (i_payload),
        .i_timestamp       (i_timestamp),
        .i_enable_index    (i_enable_index),
        .i_enable_bits     (i_enable_bits),
        .i_clear_map_first (i_clear_map_first),
        .i_take            (item_take),
        .o_item_valid      (item_valid),
        .o_item            (item)
    );

    tlrb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .pop          (pop),
        .empty        (empty),
        .o_result     (result)
    );

    assign o_accepted     = result.acc;
    assign o_pop_valid    = result.pv;
    assign o_popped_word  = result.pw;
    assign o_fill_level   = result.fill;
    assign o_drop_pending = result.drop;

endmodule

[rtl/core/tlrb_ram.sv]
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data.
// ============================================================================
module tlrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/tlrb_front.sv]
// ============================================================================
// Tagged log record ring buffer - front
// Accepts items, classifies the record size and holds them in a one-entry
// queue until the back takes them.
// ============================================================================
module tlrb_front import tlrb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [9:0]  i_record_id,
    input  logic [31:0] i_payload,
    input  logic [31:0] i_timestamp,
    input  logic [6:0]  i_enable_index,
    input  logic [7:0]  i_enable_bits,
    input  logic        i_clear_map_first,
    input  logic        i_take,
    output logic        o_item_valid,
    output t_item       o_item
);

    logic  r_q_valid;
    t_item r_q;
    t_kind kind;
    logic  accept;

    assign accept       = push && !r_q_valid;
    assign full         = r_q_valid;
    assign o_item_valid = r_q_valid;
    assign o_item       = r_q;

    // Classify record size
    always_comb begin
        unique case (t_cmd'(i_cmd))
            CMD_HALF: kind = KIND_HALF;
            CMD_WORD: kind = KIND_WORD;
            default:  kind = KIND_BYTE;
        endcase
    end

    // Queue occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (accept) begin
            r_q_valid <= 1'b1;
        end else if (i_take) begin
            r_q_valid <= 1'b0;
        end
    end

    // Hold the item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q.cmd     <= t_cmd'(i_cmd);
            r_q.kind    <= kind;
            r_q.id      <= i_record_id;
            r_q.payload <= i_payload;
            r_q.ts      <= i_timestamp;
            r_q.eidx    <= i_enable_index;
            r_q.ebits   <= i_enable_bits;
            r_q.eclr    <= i_clear_map_first;
        end
    end

endmodule

[rtl/core/tlrb_back.sv]
// ============================================================================
// Tagged log record ring buffer - back
// Sequencer that checks enables and space, writes record words into the
// ring, serves pops and queues results for the reader.
// ============================================================================
module tlrb_back import tlrb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_take,
    input  logic    pop,
    output logic    empty,
    output t_result o_result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_AEN_RD = 6'b000100,
        S_AEN_WR = 6'b001000,
        S_WRITE  = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_item                 r_it, n_it;
    logic [9:0]            r_rid, n_rid;
    logic [31:0]           r_d, n_d;
    logic                  r_open, n_open;
    logic [ADDR_W-1:0]     r_wp, n_wp;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_drop, n_drop;
    logic [31:0]           r_last, n_last;
    logic [MAP_DEPTH-1:0]  r_valid, n_valid;
    logic                  r_map_vld_q;
    logic                  r_acc, n_acc;
    logic                  r_pv, n_pv;
    logic [15:0]           r_pw, n_pw;
    logic [15:0]           r_words [4];
    logic [15:0]           n_words [4];
    logic [2:0]            r_nwords, n_nwords;
    t_result               r_oq [2];
    logic [1:0]            r_oq_cnt;
    logic                  r_oq_rd, r_oq_wr;

    logic                  oq_push, oq_pop;
    logic [9:0]            rid_in;
    logic [MAP_AW-1:0]     map_raddr, map_waddr;
    logic                  map_we;
    logic [7:0]            map_wdata, map_rdata, en_byte;
    logic                  ring_we;
    logic [ADDR_W-1:0]     ring_raddr;
    logic [15:0]           ring_rdata;
    logic [CNT_W:0]        rd_diff;
    logic                  id_ok, rec_ok, fits, small_d, med_d;
    t_kind                 kind;
    logic [31:0]           v;
    logic [1:0]            len;
    logic [15:0]           w0, w1, w2, marker;

    // Enable map and ring storage
    tlrb_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    tlrb_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (swap16(r_words[0])),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // Read addresses: record id's map byte when idle, else the always-on one
    assign rid_in    = (i_item.cmd == CMD_TIME) ? {5'b0, i_cfg.delta_id} : i_item.id;
    assign map_raddr = (r_state == S_IDLE) ? rid_in[9:3] : i_cfg.always_id[9:3];
    assign rd_diff   = (CNT_W+1)'(r_wp) - (CNT_W+1)'(r_count);
    assign ring_raddr = rd_diff[CNT_W] ? ADDR_W'(rd_diff + (CNT_W+1)'(RING_DEPTH))
                                       : ADDR_W'(rd_diff);
    assign en_byte   = r_map_vld_q ? map_rdata : 8'h00;

    // Record checks and word build
    assign small_d = (r_d[31:7] == '0) || ((&r_d[31:7]) && (r_d[6:0] != '0));
    assign med_d   = (r_d[31:15] == '0) || ((&r_d[31:15]) && (r_d[14:0] != '0));
    assign v       = (r_it.cmd == CMD_TIME) ? r_d : r_it.payload;

    always_comb begin
        if (r_it.cmd == CMD_TIME) begin
            kind = small_d ? KIND_BYTE : (med_d ? KIND_HALF : KIND_WORD);
        end else begin
            kind = r_it.kind;
        end
    end

    assign id_ok  = r_open && ({1'b0, r_rid} < 11'(ID_COUNT)) && en_byte[r_rid[2:0]];
    assign rec_ok = id_ok && ((kind != KIND_BYTE) || (r_rid < {4'b0, i_cfg.byte_limit}));
    assign len    = (kind == KIND_BYTE) ? 2'd1 : ((kind == KIND_HALF) ? 2'd2 : 2'd3);
    assign fits   = ((CNT_W+1)'(r_count) + (CNT_W+1)'(len)) < (CNT_W+1)'(RING_DEPTH);
    assign marker = {2'b00, i_cfg.marker_id, 8'h00, 1'b1};

    always_comb begin
        unique case (kind)
            KIND_HALF: begin
                w0 = {2'b01, r_rid, 2'b00, v[15], v[14] | 1'b1};
                w1 = {v[14:0], 1'b0};
                w2 = 16'h0000;
            end
            KIND_WORD: begin
                w0 = {2'b10, r_rid, 1'b0, v[31], v[30], v[29] | 1'b1};
                w1 = {v[29:15], 1'b0};
                w2 = {v[14:0], 1'b0};
            end
            default: begin
                w0 = {2'b00, r_rid[4:0], v[7:0], 1'b1};
                w1 = 16'h0000;
                w2 = 16'h0000;
            end
        endcase
    end

    assign oq_pop = pop && !empty;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_it      = r_it;
        n_rid     = r_rid;
        n_d       = r_d;
        n_open    = r_open;
        n_wp      = r_wp;
        n_count   = r_count;
        n_drop    = r_drop;
        n_last    = r_last;
        n_valid   = r_valid;
        n_acc     = r_acc;
        n_pv      = r_pv;
        n_pw      = r_pw;
        n_words   = r_words;
        n_nwords  = r_nwords;
        o_item_take = 1'b0;
        map_we    = 1'b0;
        map_waddr = r_it.eidx;
        map_wdata = r_it.ebits;
        ring_we   = 1'b0;
        oq_push   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_take = 1'b1;
                    n_it    = i_item;
                    n_rid   = rid_in;
                    n_d     = i_item.ts - r_last;
                    n_acc   = 1'b0;
                    n_pv    = 1'b0;
                    n_pw    = 16'h0000;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_RESULT;
                unique case (r_it.cmd)
                    CMD_OPEN: begin
                        if (!r_open) begin
                            n_open  = 1'b1;
                            n_valid = '0;
                            n_wp    = '0;
                            n_count = '0;
                            n_drop  = 1'b0;
                            n_last  = r_it.ts;
                            n_acc   = 1'b1;
                        end
                    end
                    CMD_CLOSE: begin
                        n_open = 1'b0;
                        n_acc  = 1'b1;
                    end
                    CMD_ENW: begin
                        if (r_open) begin
                            if (r_it.eclr) begin
                                n_valid = '0;
                            end
                            n_valid[r_it.eidx] = 1'b1;
                            map_we  = 1'b1;
                            n_state = S_AEN_RD;
                        end
                    end
                    CMD_POP: begin
                        if (r_open) begin
                            n_acc = 1'b1;
                            if (r_count != '0) begin
                                n_pv    = 1'b1;
                                n_pw    = ring_rdata;
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                    default: begin
                        if ((r_it.cmd == CMD_TIME) && (r_d == '0)) begin
                            n_acc = r_open;
                        end else if (!rec_ok) begin
                            n_acc = 1'b0;
                        end else if (!fits) begin
                            n_drop = 1'b1;
                        end else begin
                            n_acc  = 1'b1;
                            n_drop = 1'b0;
                            if (r_it.cmd == CMD_TIME) begin
                                n_last = r_it.ts;
                            end
                            if (r_drop) begin
                                n_words[0] = marker;
                                n_words[1] = w0;
                                n_words[2] = w1;
                                n_words[3] = w2;
                                n_nwords   = {1'b0, len} + 3'd1;
                            end else begin
                                n_words[0] = w0;
                                n_words[1] = w1;
                                n_words[2] = w2;
                                n_words[3] = 16'h0000;
                                n_nwords   = {1'b0, len};
                            end
                            n_state = S_WRITE;
                        end
                    end
                endcase
            end
            S_AEN_RD: begin
                n_state = S_AEN_WR;
            end
            S_AEN_WR: begin
                map_we    = 1'b1;
                map_waddr = i_cfg.always_id[9:3];
                map_wdata = en_byte | (8'h01 << i_cfg.always_id[2:0]);
                n_valid[i_cfg.always_id[9:3]] = 1'b1;
                n_acc     = 1'b1;
                n_state   = S_RESULT;
            end
            S_WRITE: begin
                ring_we    = 1'b1;
                n_words[0] = r_words[1];
                n_words[1] = r_words[2];
                n_words[2] = r_words[3];
                n_count    = r_count + 1'b1;
                n_wp       = (r_wp == ADDR_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                n_nwords   = r_nwords - 1'b1;
                if (r_nwords == 3'd1) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (r_oq_cnt != 2'd2) begin
                    oq_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= 1'b0;
            r_wp     <= '0;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_last   <= '0;
            r_valid  <= '0;
            r_nwords <= '0;
            r_oq_cnt <= '0;
            r_oq_rd  <= 1'b0;
            r_oq_wr  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_open   <= n_open;
            r_wp     <= n_wp;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_last   <= n_last;
            r_valid  <= n_valid;
            r_nwords <= n_nwords;
            r_oq_cnt <= r_oq_cnt + {1'b0, oq_push} - {1'b0, oq_pop};
            if (oq_push) begin
                r_oq_wr <= !r_oq_wr;
            end
            if (oq_pop) begin
                r_oq_rd <= !r_oq_rd;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_it        <= n_it;
        r_rid       <= n_rid;
        r_d         <= n_d;
        r_acc       <= n_acc;
        r_pv        <= n_pv;
        r_pw        <= n_pw;
        r_words     <= n_words;
        r_map_vld_q <= r_valid[map_raddr];
        if (oq_push) begin
            r_oq[r_oq_wr] <= '{acc: r_acc, pv: r_pv, pw: r_pw,
                               fill: FILL_W'(r_count), drop: r_drop};
        end
    end

    assign empty    = (r_oq_cnt == 2'd0);
    assign o_result = r_oq[r_oq_rd];

    // Checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_DEPTH))
        else $error("ring word count beyond depth");

    a_oq_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= 2'd2)
        else $error("result queue overfilled");

    a_write_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_nwords != 3'd0))
        else $error("ring write with no word pending");

    a_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_oq_cnt != 2'd2) |=> (r_state == S_IDLE))
        else $error("result not posted when queue had room");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the tagged log record ring buffer
// Drives command items through the push/full queue interface and checks every
// result popped from the result queue against an in-bench model of the
// logger: ring contents, fill level, drop flag and time delta encoding.
// ----------------------------------------------------------------------------
module tb;
    import tlrb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  cmd;
        logic [9:0]  id;
        logic [31:0] payload;
        logic [31:0] ts;
        logic [6:0]  eidx;
        logic [7:0]  ebits;
        logic        eclr;
    } t_log_item;

    typedef struct {
        logic        acc;
        logic        pv;
        logic [15:0] pw;
        logic [13:0] fill;
        logic        drop;
    } t_log_result;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_cmd;
    logic [9:0]  i_record_id;
    logic [31:0] i_payload;
    logic [31:0] i_timestamp;
    logic [6:0]  i_enable_index;
    logic [7:0]  i_enable_bits;
    logic        i_clear_map_first;
    logic        pop;
    logic        empty;
    logic        o_accepted;
    logic        o_pop_valid;
    logic [15:0] o_popped_word;
    logic [13:0] o_fill_level;
    logic        o_drop_pending;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    tagged_log_record_ring_buffer_top u_dut (.*);

    // Logger shadow state
    logic [15:0] ring_mem [RING_DEPTH];
    int unsigned wr_ptr, n_words;
    logic        drop_flag, is_open;
    logic [7:0]  id_map [MAP_DEPTH];
    logic [31:0] last_time;
    logic [4:0]  delta_id, marker_id;
    logic [9:0]  always_id;
    logic [5:0]  byte_lim;

    t_log_item   pending_items [$];
    t_log_result expected_results [$];
    int          errors = 0;
    int          n_pushed = 0, n_popped = 0, n_valid_pops = 0, n_drops = 0;
    bit          calm_phase = 0;
    bit          hold_reader = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void store_word(logic [15:0] w);
        ring_mem[wr_ptr] = {w[7:0], w[15:8]};
        n_words++;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    endfunction

    function automatic bit id_on(logic [9:0] id);
        return is_open && id_map[id[9:3]][id[2:0]];
    endfunction

    // Append a record, preceded by a drop marker when one is owed
    function automatic bit append_record(logic [15:0] w0, logic [15:0] w1,
                                         logic [15:0] w2, int len);
        if (n_words + len >= RING_DEPTH) begin
            drop_flag = 1;
            n_drops++;
            return 0;
        end
        if (drop_flag) begin
            store_word(16'h0001 | (16'(marker_id) << 9));
            drop_flag = 0;
        end
        store_word(w0);
        if (len > 1) store_word(w1);
        if (len > 2) store_word(w2);
        return 1;
    endfunction

    function automatic bit log_byte(logic [9:0] id, logic [31:0] v);
        if (!id_on(id) || id >= byte_lim) return 0;
        return append_record(16'h0001 | (16'(id[4:0]) << 9) | (16'(v[7:0]) << 1),
                             0, 0, 1);
    endfunction

    function automatic bit log_half(logic [9:0] id, logic [31:0] v);
        if (!id_on(id)) return 0;
        return append_record(16'h4001 | (16'(id) << 4) | 16'(v[15:14]),
                             {v[14:0], 1'b0}, 0, 2);
    endfunction

    function automatic bit log_word(logic [9:0] id, logic [31:0] v);
        if (!id_on(id)) return 0;
        return append_record(16'h8001 | (16'(id) << 4) | 16'(v[31:29]),
                             {v[29:15], 1'b0}, {v[14:0], 1'b0}, 3);
    endfunction

    function automatic t_log_result predict_log_step(t_log_item it);
        t_log_result r;
        logic [31:0] d, mag;
        r = '{default: 0};
        case (t_cmd'(it.cmd))
            CMD_OPEN: if (!is_open) begin
                is_open = 1;
                foreach (id_map[k]) id_map[k] = 0;
                wr_ptr = 0;
                n_words = 0;
                drop_flag = 0;
                last_time = it.ts;
                r.acc = 1;
            end
            CMD_CLOSE: begin
                is_open = 0;
                r.acc = 1;
            end
            CMD_ENW: if (is_open) begin
                if (it.eclr) foreach (id_map[k]) id_map[k] = 0;
                id_map[it.eidx] = it.ebits;
                id_map[always_id[9:3]][always_id[2:0]] = 1'b1;
                r.acc = 1;
            end
            CMD_BYTE: r.acc = log_byte(it.id, it.payload);
            CMD_HALF: r.acc = log_half(it.id, it.payload);
            CMD_WORD: r.acc = log_word(it.id, it.payload);
            CMD_TIME: begin
                if (it.ts == last_time) begin
                    r.acc = is_open;
                end else begin
                    d = it.ts - last_time;
                    mag = d[31] ? -d : d;
                    if (d == 32'h8000_0000) mag = d;
                    if (mag <= 127) r.acc = log_byte(10'(delta_id), d);
                    else if (mag <= 32767) r.acc = log_half(10'(delta_id), d);
                    else r.acc = log_word(10'(delta_id), d);
                    if (r.acc) last_time = it.ts;
                end
            end
            default: if (is_open) begin
                r.acc = 1;
                if (n_words != 0) begin
                    r.pw = ring_mem[(wr_ptr + RING_DEPTH - n_words) % RING_DEPTH];
                    n_words--;
                    r.pv = 1;
                end
            end
        endcase
        r.fill = 14'(n_words);
        r.drop = drop_flag;
        return r;
    endfunction

    // Driver: offer queued items, with random idle bursts
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_log_item it;
        if (!i_rst_n) begin
            push <= 0;
        end else begin
            if (push && !full) begin
                expected_results.push_back(predict_log_step(pending_items.pop_front()));
                n_pushed++;
            end
            if (send_gap > 0) begin
                send_gap--;
                push <= 0;
            end else if (!calm_phase && $urandom_range(0, 19) == 0) begin
                send_gap = $urandom_range(1, 15);
                push <= 0;
            end else if (pending_items.size() > ((push && !full) ? 0 : 0)) begin
                it = pending_items[0];
                push <= 1;
                i_cmd <= it.cmd;
                i_record_id <= it.id;
                i_payload <= it.payload;
                i_timestamp <= it.ts;
                i_enable_index <= it.eidx;
                i_enable_bits <= it.ebits;
                i_clear_map_first <= it.eclr;
            end else begin
                push <= 0;
            end
        end
    end

    // Monitor: accept results, compare with the oldest prediction
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_log_result e;
        if (!i_rst_n) begin
            pop <= 0;
        end else begin
            if (pop && !empty) begin
                n_popped++;
                if (expected_results.size() == 0) begin
                    $error("result with no prediction waiting");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.pv) n_valid_pops++;
                    if (o_accepted !== e.acc) begin
                        $error("accepted exp %0d got %0d", e.acc, o_accepted);
                        errors++;
                    end
                    if (o_pop_valid !== e.pv) begin
                        $error("pop_valid exp %0d got %0d", e.pv, o_pop_valid);
                        errors++;
                    end
                    if (o_popped_word !== e.pw) begin
                        $error("popped_word exp %h got %h", e.pw, o_popped_word);
                        errors++;
                    end
                    if (o_fill_level !== e.fill) begin
                        $error("fill_level exp %0d got %0d", e.fill, o_fill_level);
                        errors++;
                    end
                    if (o_drop_pending !== e.drop) begin
                        $error("drop_pending exp %0d got %0d", e.drop, o_drop_pending);
                        errors++;
                    end
                end
            end
            if (hold_reader) begin
                pop <= 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 0;
            end else if (!calm_phase && $urandom_range(0, 19) == 0) begin
                recv_gap = $urandom_range(1, 15);
                pop <= 0;
            end else begin
                pop <= 1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || hold_reader) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_log_item rand_item();
        t_log_item it;
        it.cmd = 3'($urandom);
        it.id = 10'($urandom);
        it.payload = $urandom;
        it.ts = $urandom;
        it.eidx = 7'($urandom);
        it.ebits = 8'($urandom);
        it.eclr = 1'($urandom);
        return it;
    endfunction

    function automatic t_log_item mk(t_cmd c, logic [9:0] id = 0,
                                     logic [31:0] pl = 0, logic [31:0] ts = 0);
        t_log_item it;
        it = rand_item();
        it.cmd = c;
        it.id = id;
        it.payload = pl;
        it.ts = ts;
        return it;
    endfunction

    function automatic t_log_item mk_enable(logic [6:0] idx, logic [7:0] bits,
                                            logic clr);
        t_log_item it;
        it = mk(CMD_ENW);
        it.eidx = idx;
        it.ebits = bits;
        it.eclr = clr;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [9:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            CFG_DELTA_ID:  delta_id = val[4:0];
            CFG_MARKER_ID: marker_id = val[4:0];
            CFG_ALWAYS_ID: always_id = val;
            default:       byte_lim = val[5:0];
        endcase
    endtask

    // Close and reopen, enable a random slice of ids plus the delta and common
    // ids, then a mostly well-formed stream of records, time items and pops
    task automatic queue_session(int n, logic [31:0] t0);
        t_log_item it;
        logic [31:0] t;
        int r;
        t = t0;
        pending_items.push_back(mk(CMD_CLOSE));
        pending_items.push_back(mk(CMD_OPEN, 0, 0, t));
        pending_items.push_back(mk_enable(7'(delta_id >> 3), 8'hFF, 1));
        pending_items.push_back(mk_enable(0, 8'($urandom), 0));
        pending_items.push_back(mk_enable(7'($urandom), 8'($urandom), 0));
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            it = rand_item();
            if (r < 12) begin
                it.cmd = CMD_BYTE;
                it.id = 10'($urandom_range(0, 31));
            end else if (r < 24) begin
                it.cmd = CMD_HALF;
                it.id = $urandom_range(0, 3) == 0 ? it.id : 10'($urandom_range(0, 15));
            end else if (r < 36) begin
                it.cmd = CMD_WORD;
                it.id = $urandom_range(0, 3) == 0 ? it.id : 10'($urandom_range(0, 15));
            end else if (r < 56) begin
                it.cmd = CMD_TIME;
                case ($urandom_range(0, 4))
                    0: it.ts = t + 32'($urandom_range(0, 254)) - 127;
                    1: it.ts = t + 32'($urandom_range(0, 65534)) - 32767;
                    2: it.ts = t;
                    3: it.ts = t + 32'h8000_0000;
                    default: it.ts = $urandom;
                endcase
                t = it.ts;
            end else if (r < 90) begin
                it.cmd = CMD_POP;
            end else if (r < 94) begin
                it.cmd = CMD_ENW;
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        i_rst_n = 0;
        push = 0;
        pop = 0;
        i_cmd = 0;
        i_record_id = 0;
        i_payload = 0;
        i_timestamp = 0;
        i_enable_index = 0;
        i_enable_bits = 0;
        i_clear_map_first = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        wr_ptr = 0;
        n_words = 0;
        drop_flag = 0;
        is_open = 0;
        last_time = 0;
        delta_id = 0;
        marker_id = 1;
        always_id = 2;
        byte_lim = 32;
        foreach (id_map[k]) id_map[k] = 0;
        foreach (ring_mem[k]) ring_mem[k] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: closed refusals, open twice, extremes of fields
        pending_items.push_back(mk(CMD_POP));
        pending_items.push_back(mk(CMD_BYTE, 2, 32'hFF));
        pending_items.push_back(mk_enable(0, 8'hFF, 0));
        pending_items.push_back(mk(CMD_TIME, 0, 0, 32'h10));
        pending_items.push_back(mk(CMD_OPEN, 0, 0, 32'hFFFF_FFF0));
        pending_items.push_back(mk(CMD_OPEN, 0, 0, 0));
        pending_items.push_back(mk(CMD_BYTE, 2, 32'hFF));
        pending_items.push_back(mk_enable(7'd127, 8'hFF, 1));
        pending_items.push_back(mk_enable(0, 8'h01, 0));
        pending_items.push_back(mk(CMD_BYTE, 0, 32'hFFFF_FFFF));
        pending_items.push_back(mk(CMD_HALF, 10'd1023, 32'hFFFF_FFFF));
        pending_items.push_back(mk(CMD_WORD, 10'd1016, 32'hFFFF_FFFF));
        pending_items.push_back(mk(CMD_WORD, 2, 32'h0));
        pending_items.push_back(mk(CMD_BYTE, 10'd1023, 32'h5A));
        pending_items.push_back(mk(CMD_TIME, 0, 0, 32'hFFFF_FFF0));
        pending_items.push_back(mk(CMD_TIME, 0, 0, 32'h0000_006F));
        pending_items.push_back(mk(CMD_TIME, 0, 0, 32'h0000_0000));
        pending_items.push_back(mk(CMD_TIME, 0, 0, 32'h0000_7FFF));
        pending_items.push_back(mk(CMD_TIME, 0, 0, 32'h8000_7FFF));
        pending_items.push_back(mk(CMD_TIME, 0, 0, 32'h0000_0000));
        for (int k = 0; k < 5; k++) pending_items.push_back(mk(CMD_POP));
        wait_drained();

        // Back up the input with a burst of records while the reader stalls
        write_reg(CFG_DELTA_ID, 10'd31);
        write_reg(CFG_MARKER_ID, 10'd0);
        write_reg(CFG_ALWAYS_ID, 10'd1023);
        write_reg(CFG_BYTE_LIM, 10'd0);
        pending_items.push_back(mk(CMD_CLOSE));
        pending_items.push_back(mk(CMD_OPEN, 0, 0, 32'h1234));
        pending_items.push_back(mk_enable(1, 8'h0F, 0));
        for (int k = 0; k < 120; k++)
            pending_items.push_back(mk(CMD_WORD, 10'd1023, $urandom));
        pending_items.push_back(mk(CMD_HALF, 10'd8, 32'hA5A5));
        pending_items.push_back(mk(CMD_BYTE, 10'd8, 32'h11));
        pending_items.push_back(mk(CMD_POP));
        pending_items.push_back(mk(CMD_POP));
        pending_items.push_back(mk(CMD_HALF, 10'd9, 32'h1234));
        hold_reader = 1;
        repeat (300) @(posedge i_clk);
        hold_reader = 0;
        wait_drained();

        // Random phases over several register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_DELTA_ID, 10'($urandom_range(0, 31)));
            write_reg(CFG_MARKER_ID, 10'($urandom_range(0, 31)));
            write_reg(CFG_ALWAYS_ID, ph == 0 ? 10'd0 : 10'($urandom));
            write_reg(CFG_BYTE_LIM, ph == 0 ? 10'd32 : 10'($urandom_range(0, 32)));
            if (ph == 3) calm_phase = 1;
            queue_session(120, $urandom);
            for (int k = 0; k < 20; k++) pending_items.push_back(rand_item());
            wait_drained();
        end

        $display("Ran %0d items, %0d words popped, %0d refused for a full ring",
                 n_pushed, n_valid_pops, n_drops);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[files.f]
rtl/core/tlrb_pkg.sv
rtl/core/tlrb_ram.sv
rtl/core/tlrb_front.sv
rtl/core/tlrb_back.sv
rtl/core/tagged_log_record_ring_buffer_top.sv
test/tb.sv
